// ===== rtl/rrts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int MAX_TASKS = 8;
	localparam int TASK_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = 4;
	localparam int LEN_W     = 8;
	localparam int TICK_W    = 16;
	localparam int EV_W      = 3;
	localparam int ACT_W     = 2;
	localparam int PH_W      = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;

	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

	localparam logic [PH_W-1:0] PH_NEW   = 2'd0;
	localparam logic [PH_W-1:0] PH_READY = 2'd1;
	localparam logic [PH_W-1:0] PH_RUN   = 2'd2;
	localparam logic [PH_W-1:0] PH_DONE  = 2'd3;

	localparam logic [EV_W-1:0] EV_ACK      = 3'd0;
	localparam logic [EV_W-1:0] EV_RAN      = 3'd1;
	localparam logic [EV_W-1:0] EV_PREEMPT  = 3'd2;
	localparam logic [EV_W-1:0] EV_FINISH   = 3'd3;
	localparam logic [EV_W-1:0] EV_ALL_DONE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b1;

	localparam logic [LEN_W-1:0]  QUANTUM_RST = 8'd4;
	localparam logic [CNT_W-1:0]  COUNT_RST   = 4'd1;
	localparam logic [LEN_W-1:0]  SAT_8       = '1;
	localparam logic [TICK_W-1:0] SAT_16      = '1;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage : rrts_pkg
`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ctrl
// Two-state sequencer: take an item, then write it back once the result
// register is free.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output dp_cmd_t   cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_COMMIT = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_COMMIT))
		else $error("accepted item did not move to write-back");

	a_commit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("write-back without a result beat");

	a_stall_holds_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && out_valid_q && !out_ready) |=> (state_q == S_COMMIT))
		else $error("write-back left while result slot was full");

	a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> !cmd.capture)
		else $error("item taken during write-back");

endmodule : rrts_ctrl
`default_nettype wire

// ===== rtl/rrts_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_dp
// Task table, scan stage (admission, cyclic ready search, time arithmetic)
// and write-back stage with the result register.
// ----------------------------------------------------------------------------
module rrts_dp
	import rrts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic [ACT_W-1:0]      action,
	input  wire logic [TASK_W-1:0]     task_slot,
	input  wire logic [LEN_W-1:0]      task_length,
	output logic [EV_W-1:0]            event_res,
	output logic [TASK_W-1:0]          ran_task,
	output logic [TICK_W-1:0]          tick_number,
	output logic [TICK_W-1:0]          turnaround,
	output logic [TICK_W-1:0]          waiting
);

	// configuration
	logic [LEN_W-1:0] quantum_q;
	logic [CNT_W-1:0] task_count_q;

	// task table and scheduler state
	logic [PH_W-1:0]   phase_q [MAX_TASKS];
	logic [LEN_W-1:0]  len_q   [MAX_TASKS];
	logic [LEN_W-1:0]  exec_q  [MAX_TASKS];
	logic [TICK_W-1:0] arr_q   [MAX_TASKS];
	logic [TASK_W-1:0] cur_q;
	logic [LEN_W-1:0]  slice_q;
	logic [TICK_W-1:0] tick_q;

	// scan stage, combinational
	logic [CNT_W-1:0]     n_c;
	logic [MAX_TASKS-1:0] in_batch_c;
	logic [MAX_TASKS-1:0] ready_c;
	logic [MAX_TASKS-1:0] live_vec_c;
	logic [PH_W-1:0]      phase_a_c [MAX_TASKS];
	logic                 admit_c;
	logic [TASK_W-1:0]    admit_k_c;
	logic [TASK_W-1:0]    cur0_c;
	logic                 run_here_c;
	logic                 pick_ok_c;
	logic [TASK_W-1:0]    pick_c;
	logic [TASK_W-1:0]    idx_c;
	logic                 found_c;
	logic [TASK_W-1:0]    c_c;
	logic [MAX_TASKS-1:0] c_hot_c;
	logic                 ready_other_c;
	logic [LEN_W:0]       ex_sum_c;
	logic [LEN_W-1:0]     ex_c;
	logic [TICK_W-1:0]    arr_c;
	logic [TICK_W-1:0]    fin_c;
	logic [TICK_W-1:0]    turn_c;

	// scan stage registers
	logic [ACT_W-1:0]  act_s1;
	logic [TASK_W-1:0] slot_s1;
	logic [LEN_W-1:0]  length_s1;
	logic [CNT_W-1:0]  n_s1;
	logic              admit_s1;
	logic [TASK_W-1:0] admit_k_s1;
	logic              live_s1;
	logic [TASK_W-1:0] cur0_s1;
	logic              found_s1;
	logic [TASK_W-1:0] c_s1;
	logic              ready_other_s1;
	logic [LEN_W-1:0]  ex_s1;
	logic [TICK_W-1:0] turn_s1;
	logic              finish_s1;

	// write-back stage, combinational
	logic              preempt_c;
	logic [TASK_W-1:0] next_c;
	logic [TICK_W-1:0] wait_c;
	logic [EV_W-1:0]   ev_c;

	always_comb begin
		n_c = (task_count_q > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : task_count_q;

		admit_c   = 1'b0;
		admit_k_c = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			in_batch_c[i] = (CNT_W'(i) < n_c);
			if (in_batch_c[i] && phase_q[i] == PH_NEW) begin
				admit_c   = 1'b1;
				admit_k_c = TASK_W'(i);
			end
		end

		for (int i = 0; i < MAX_TASKS; i++) begin
			phase_a_c[i] = (admit_c && admit_k_c == TASK_W'(i)) ? PH_READY : phase_q[i];
			ready_c[i]    = in_batch_c[i] && (phase_a_c[i] == PH_READY);
			live_vec_c[i] = in_batch_c[i] && (phase_a_c[i] != PH_DONE);
		end

		cur0_c     = (CNT_W'(cur_q) >= n_c) ? '0 : cur_q;
		run_here_c = (phase_a_c[cur0_c] == PH_RUN);

		// cyclic search from cur0; entries outside the batch are never ready,
		// so wrapping at MAX_TASKS matches wrapping at the task count
		pick_ok_c = 1'b0;
		pick_c    = '0;
		for (int d = MAX_TASKS - 1; d >= 0; d--) begin
			idx_c = cur0_c + TASK_W'(d);
			if (ready_c[idx_c]) begin
				pick_ok_c = 1'b1;
				pick_c    = idx_c;
			end
		end

		found_c = run_here_c || pick_ok_c;
		c_c     = run_here_c ? cur0_c : pick_c;

		c_hot_c       = '0;
		c_hot_c[c_c]  = 1'b1;
		ready_other_c = |(ready_c & ~c_hot_c);

		ex_sum_c = {1'b0, exec_q[c_c]} + (LEN_W+1)'(1);
		ex_c     = ex_sum_c[LEN_W] ? SAT_8 : ex_sum_c[LEN_W-1:0];

		arr_c  = (admit_c && admit_k_c == c_c) ? tick_q : arr_q[c_c];
		fin_c  = (tick_q == SAT_16) ? SAT_16 : tick_q + TICK_W'(1);
		turn_c = (fin_c >= arr_c) ? fin_c - arr_c : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1         <= action;
			slot_s1        <= task_slot;
			length_s1      <= task_length;
			n_s1           <= n_c;
			admit_s1       <= admit_c;
			admit_k_s1     <= admit_k_c;
			live_s1        <= |live_vec_c;
			cur0_s1        <= cur0_c;
			found_s1       <= found_c;
			c_s1           <= c_c;
			ready_other_s1 <= ready_other_c;
			ex_s1          <= ex_c;
			turn_s1        <= turn_c;
			finish_s1      <= (ex_c >= len_q[c_c]);
		end
	end

	always_comb begin
		preempt_c = (slice_q >= quantum_q) && ready_other_s1;
		next_c    = ((CNT_W'(c_s1) + CNT_W'(1)) >= n_s1) ? '0 : c_s1 + TASK_W'(1);
		wait_c    = (turn_s1 >= TICK_W'(ex_s1)) ? turn_s1 - TICK_W'(ex_s1) : '0;
		ev_c      = EV_ACK;
		if (act_s1 == ACT_TICK) begin
			if (!live_s1) begin
				ev_c = EV_ALL_DONE;
			end else if (found_s1) begin
				if (finish_s1) begin
					ev_c = EV_FINISH;
				end else if (preempt_c) begin
					ev_c = EV_PREEMPT;
				end else begin
					ev_c = EV_RAN;
				end
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RST;
			task_count_q <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUANTUM:    quantum_q    <= cfg_wdata[LEN_W-1:0];
				CFG_TASK_COUNT: task_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// lengths hold whatever was loaded; no reset
	always_ff @(posedge clk) begin
		if (cmd.commit && act_s1 == ACT_LOAD) begin
			len_q[slot_s1] <= length_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				phase_q[i] <= PH_DONE;
				exec_q[i]  <= '0;
				arr_q[i]   <= '0;
			end
			cur_q   <= '0;
			slice_q <= LEN_W'(1);
			tick_q  <= '0;
		end else if (cmd.commit) begin
			case (act_s1)
				ACT_START: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						phase_q[i] <= (CNT_W'(i) < n_s1) ? PH_NEW : PH_DONE;
						exec_q[i]  <= '0;
						arr_q[i]   <= '0;
					end
					cur_q   <= '0;
					slice_q <= LEN_W'(1);
					tick_q  <= '0;
				end
				ACT_TICK: begin
					if (admit_s1) begin
						arr_q[admit_k_s1] <= tick_q;
						// the task that ran takes its phase from the outcome below
						if (!(found_s1 && admit_k_s1 == c_s1)) begin
							phase_q[admit_k_s1] <= PH_READY;
						end
					end
					if (live_s1) begin
						if (!found_s1) begin
							cur_q <= cur0_s1;
						end else begin
							exec_q[c_s1] <= ex_s1;
							if (tick_q != SAT_16) begin
								tick_q <= tick_q + TICK_W'(1);
							end
							if (finish_s1) begin
								phase_q[c_s1] <= PH_DONE;
								cur_q         <= c_s1;
								slice_q       <= LEN_W'(1);
							end else if (preempt_c) begin
								phase_q[c_s1] <= PH_READY;
								cur_q         <= next_c;
								slice_q       <= LEN_W'(1);
							end else begin
								phase_q[c_s1] <= PH_RUN;
								cur_q         <= c_s1;
								if (slice_q != SAT_8) begin
									slice_q <= slice_q + LEN_W'(1);
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			event_res   <= ev_c;
			ran_task    <= (ev_c == EV_RAN || ev_c == EV_PREEMPT || ev_c == EV_FINISH)
				? c_s1 : '0;
			tick_number <= (act_s1 == ACT_START) ? '0 : tick_q;
			turnaround  <= (ev_c == EV_FINISH) ? turn_s1 : '0;
			waiting     <= (ev_c == EV_FINISH) ? wait_c : '0;
		end
	end

endmodule : rrts_dp
`default_nettype wire

// ===== rtl/round_robin_task_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler with a time quantum over up to eight tasks.
// ----------------------------------------------------------------------------
// Every item (load length, start batch, tick) yields exactly one result beat.
// An item first passes the scan stage (admit the lowest new task, search
// cyclically for the running or next ready task, form the executed count and
// turnaround), then the write-back stage (write the table back and load the
// result register). Write-back waits while the result register holds a beat
// that has not been taken, so a stalled output stretches the item; a new item
// is taken only after the last one has been written back. Configuration writes
// (quantum, task count) take effect at once and belong to idle periods only.
module round_robin_task_scheduler
	import rrts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ACT_W-1:0]      action,
	input  wire logic [TASK_W-1:0]     task_slot,
	input  wire logic [LEN_W-1:0]      task_length,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [EV_W-1:0]            event_res,
	output logic [TASK_W-1:0]          ran_task,
	output logic [TICK_W-1:0]          tick_number,
	output logic [TICK_W-1:0]          turnaround,
	output logic [TICK_W-1:0]          waiting
);

	dp_cmd_t cmd;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rrts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.action      (action),
		.task_slot   (task_slot),
		.task_length (task_length),
		.event_res   (event_res),
		.ran_task    (ran_task),
		.tick_number (tick_number),
		.turnaround  (turnaround),
		.waiting     (waiting)
	);

endmodule : round_robin_task_scheduler
`default_nettype wire
